// File: hw/rtl/three_state_life_automaton_macros.svh
// assertion helpers for the life automaton top level
// expects signals named clk and rst in the scope of use
`ifndef THREE_STATE_LIFE_AUTOMATON_MACROS_SVH
`define THREE_STATE_LIFE_AUTOMATON_MACROS_SVH

// property that must hold on every clock edge outside reset
`define TSLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define TSLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tsla_pkg.sv
// shared constants, types and the cell update rule of the life automaton
// used by the controller, the datapath and the top level
package tsla_pkg;

  localparam int GRID_SIDE = 64;
  localparam int ROW_W     = $clog2(GRID_SIDE);
  localparam int SWEEP_W   = $clog2(GRID_SIDE + 1);
  localparam int SHIFT_W   = $clog2(GRID_SIDE + 2);
  localparam int CELL_W    = 2;
  localparam int FIELD_W   = 6;
  localparam int GEN_W     = 16;
  localparam int PADDR_W   = 3;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_ADVANCE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [CELL_W-1:0] CELL_EMPTY   = 2'd0;
  localparam logic [CELL_W-1:0] CELL_DORMANT = 2'd1;
  localparam logic [CELL_W-1:0] CELL_ALIVE   = 2'd2;
  localparam logic [CELL_W-1:0] CELL_BAD     = 2'd3;

  // one grid row, cell c in element c
  typedef logic [GRID_SIDE-1:0][CELL_W-1:0] line_t;

  typedef struct packed {
    logic             win_clear;
    logic             rd_en;
    logic             rd_item;
    logic             rd_zero;
    logic [ROW_W-1:0] addr;
    logic             clr_wr;
    logic             item_load;
    logic             cell_done;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic changed;
    logic out_free;
  } dp_stat_t;

  function automatic logic [CELL_W-1:0] cell_rule(logic [CELL_W-1:0] cur, logic [3:0] cnt);
    logic [CELL_W-1:0] nxt;
    nxt = cur;
    case (cur)
      CELL_EMPTY:   if (cnt == 4'd3) nxt = CELL_ALIVE;
      CELL_DORMANT: if (cnt == 4'd2) nxt = CELL_ALIVE;
      CELL_ALIVE: begin
        if (cnt < 4'd2) nxt = CELL_EMPTY;
        else if (cnt > 4'd3) nxt = CELL_DORMANT;
      end
      default: nxt = cur;
    endcase
    return nxt;
  endfunction

endpackage

// File: hw/rtl/tsla_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tsla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/tsla_ctrl.sv
// sequencer of the life automaton: clearing pass, cell access, generation sweeps
// depends on tsla_pkg
module tsla_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [1:0]                    in_kind,
  output logic                          in_ready,
  input  logic [tsla_pkg::GEN_W-1:0]    generations,
  input  tsla_pkg::dp_stat_t            stat,
  output tsla_pkg::dp_cmd_t             cmd,
  output logic                          clearing
);

  typedef enum logic [6:0] {
    ST_CLEAR     = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_CELL_RD   = 7'b0000100,
    ST_CELL_DONE = 7'b0001000,
    ST_GEN_READ  = 7'b0010000,
    ST_GEN_DRAIN = 7'b0100000,
    ST_FINISH    = 7'b1000000
  } state_t;

  localparam logic [tsla_pkg::SWEEP_W-1:0] LAST_ROW = tsla_pkg::SWEEP_W'(tsla_pkg::GRID_SIDE - 1);
  localparam logic [tsla_pkg::SWEEP_W-1:0] FLUSH    = tsla_pkg::SWEEP_W'(tsla_pkg::GRID_SIDE);

  state_t                       state, state_next;
  logic [tsla_pkg::SWEEP_W-1:0] cnt, cnt_next;
  logic [tsla_pkg::GEN_W-1:0]   left, left_next;

  assign in_ready = (state == ST_IDLE);
  assign clearing = (state == ST_CLEAR);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    left_next  = left;
    cmd        = '0;
    cmd.addr   = cnt[tsla_pkg::ROW_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == LAST_ROW) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          case (in_kind) inside
            tsla_pkg::CMD_WRITE, tsla_pkg::CMD_READ: state_next = ST_CELL_RD;
            tsla_pkg::CMD_ADVANCE: begin
              left_next = generations;
              if (generations == '0) begin
                state_next = ST_FINISH;
              end else begin
                cmd.win_clear = 1'b1;
                cnt_next      = '0;
                state_next    = ST_GEN_READ;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CELL_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_item = 1'b1;
        state_next  = ST_CELL_DONE;
      end
      ST_CELL_DONE: begin
        cmd.cell_done = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_GEN_READ: begin
        // the extra step past the last row shifts in the empty border
        cmd.rd_en   = 1'b1;
        cmd.rd_zero = (cnt == FLUSH);
        cnt_next    = cnt + 1'b1;
        if (cnt == FLUSH) state_next = ST_GEN_DRAIN;
      end
      ST_GEN_DRAIN: begin
        if (!stat.pipe_busy) begin
          if (!stat.changed || left == 16'd1) begin
            state_next = ST_FINISH;
          end else begin
            left_next     = left - 1'b1;
            cmd.win_clear = 1'b1;
            cnt_next      = '0;
            state_next    = ST_GEN_READ;
          end
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      left  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      left  <= left_next;
    end
  end

endmodule

// File: hw/rtl/tsla_datapath.sv
// grid store, three-row window with the per-lane update rule, cell access and result register
// depends on tsla_pkg and tsla_ram
module tsla_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  tsla_pkg::dp_cmd_t               cmd,
  output tsla_pkg::dp_stat_t              stat,
  input  logic [tsla_pkg::FIELD_W-1:0]    row,
  input  logic [tsla_pkg::FIELD_W-1:0]    column,
  input  logic [tsla_pkg::CELL_W-1:0]     cell_in,
  input  logic [1:0]                      kind,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [tsla_pkg::CELL_W-1:0]     cell_out,
  output logic [1:0]                      finished_kind
);

  localparam int N = tsla_pkg::GRID_SIDE;

  logic [tsla_pkg::ROW_W-1:0]   item_row, item_col;
  logic [tsla_pkg::CELL_W-1:0]  item_val, res_cell;
  logic                         item_inside;
  logic [1:0]                   item_kind;
  tsla_pkg::line_t              up, mid, dn, rdata, new_line, mod_line, wdata;
  logic                         rd_valid, rd_zero_q, wv, changed;
  logic [tsla_pkg::SHIFT_W-1:0] sh;
  logic [tsla_pkg::ROW_W-1:0]   wrow, waddr, raddr;
  logic                         cell_wr, we;
  logic [N+1:0]                 al_up, al_mid, al_dn;

  // new value of every cell of the middle row, one lane per column
  always_comb begin
    al_up  = '0;
    al_mid = '0;
    al_dn  = '0;
    for (int c = 0; c < N; c++) begin
      al_up[c+1]  = (up[c]  == tsla_pkg::CELL_ALIVE);
      al_mid[c+1] = (mid[c] == tsla_pkg::CELL_ALIVE);
      al_dn[c+1]  = (dn[c]  == tsla_pkg::CELL_ALIVE);
    end
    for (int c = 0; c < N; c++) begin
      new_line[c] = tsla_pkg::cell_rule(mid[c],
        4'(al_up[c]) + 4'(al_up[c+1]) + 4'(al_up[c+2]) + 4'(al_mid[c]) +
        4'(al_mid[c+2]) + 4'(al_dn[c]) + 4'(al_dn[c+1]) + 4'(al_dn[c+2]));
    end
  end

  always_comb begin
    mod_line           = rdata;
    mod_line[item_col] = item_val;
  end

  assign cell_wr = cmd.cell_done && item_kind == tsla_pkg::CMD_WRITE && item_inside &&
                   item_val != tsla_pkg::CELL_BAD;
  assign we      = cmd.clr_wr | wv | cell_wr;
  assign waddr   = cmd.clr_wr ? cmd.addr : (wv ? wrow : item_row);
  assign wdata   = cmd.clr_wr ? '0 : (wv ? new_line : mod_line);
  assign raddr   = cmd.rd_item ? item_row : cmd.addr;

  tsla_ram #(
    .WIDTH($bits(tsla_pkg::line_t)),
    .DEPTH(N)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_en & ~cmd.rd_zero),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_row    <= tsla_pkg::ROW_W'(row);
      item_col    <= tsla_pkg::ROW_W'(column);
      item_val    <= cell_in;
      item_kind   <= kind;
      item_inside <= (32'(row) < N) && (32'(column) < N);
      res_cell    <= tsla_pkg::CELL_EMPTY;
    end
    if (cmd.cell_done) begin
      res_cell <= (item_kind == tsla_pkg::CMD_READ && item_inside) ? rdata[item_col]
                                                                   : tsla_pkg::CELL_EMPTY;
    end
    if (cmd.win_clear) begin
      up  <= '0;
      mid <= '0;
      dn  <= '0;
    end else if (rd_valid) begin
      up  <= mid;
      mid <= dn;
      dn  <= rd_zero_q ? '0 : rdata;
    end
    wrow      <= tsla_pkg::ROW_W'(sh - 1'b1);
    rd_zero_q <= cmd.rd_zero;
    if (cmd.out_load) begin
      cell_out      <= res_cell;
      finished_kind <= item_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      wv        <= 1'b0;
      sh        <= '0;
      changed   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en & ~cmd.rd_item;
      if (cmd.win_clear) begin
        sh      <= '0;
        changed <= 1'b0;
        wv      <= 1'b0;
      end else begin
        // a row is complete once the row below it is in the window
        wv <= rd_valid && (sh != '0);
        if (rd_valid) sh <= sh + 1'b1;
        if (wv && new_line != mid) changed <= 1'b1;
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign stat.pipe_busy = rd_valid | wv;
  assign stat.changed   = changed;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// File: hw/rtl/three_state_life_automaton.sv
// three-state life automaton on a 64 x 64 grid, one row of 64 cells per store word
// write and read: the command steps through cell read, cell done and finish, and m_tvalid is
// registered; an advance reads the 64 store rows and then the empty border row for each
// generation, drains the window, and stops early on a stable grid; one command is in work at a
// time; reset (synchronous) runs a clearing pass over all 64 store rows with s_tready low;
// generations resets to 1
`include "three_state_life_automaton_macros.svh"
module three_state_life_automaton (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,  // row[5:0], column[11:6], cell_in[13:12]
  input  logic [1:0]                     s_tuser,  // command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,  // cell_out[1:0]
  output logic [1:0]                     m_tuser,  // finished_kind
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tsla_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [tsla_pkg::GEN_W-1:0]  generations;
  tsla_pkg::dp_cmd_t           cmd;
  tsla_pkg::dp_stat_t          stat;
  logic                        clearing;
  logic [tsla_pkg::CELL_W-1:0] cell_out;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(generations);

  always_ff @(posedge clk) begin
    if (rst) begin
      generations <= 16'd1;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      generations <= pwdata[tsla_pkg::GEN_W-1:0];
    end
  end

  tsla_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_kind    (s_tuser),
    .in_ready   (s_tready),
    .generations(generations),
    .stat       (stat),
    .cmd        (cmd),
    .clearing   (clearing)
  );

  tsla_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .row          (s_tdata[5:0]),
    .column       (s_tdata[11:6]),
    .cell_in      (s_tdata[13:12]),
    .kind         (s_tuser),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .cell_out     (cell_out),
    .finished_kind(m_tuser)
  );

  assign m_tdata = 8'(cell_out);

  `TSLA_ASSERT(a_no_transfer_clearing, !(clearing && s_tready), "input taken during clearing")
  `TSLA_ASSERT(a_no_result_unused, !(m_tvalid && m_tuser == tsla_pkg::CMD_NONE), "result for unused command")
  `TSLA_ASSERT_NXT(a_unused_stays_ready, s_tvalid && s_tready && s_tuser == tsla_pkg::CMD_NONE, s_tready, "unused command stalled input")

endmodule

// File: test/tb.sv
// testbench for three_state_life_automaton: command stream in, one result per write, advance or read out
// keeps its own copy of the grid and predicts every result; depends on tsla_pkg and the rtl
`timescale 1ns / 100ps
module tb;

  typedef struct {
    logic [1:0] cmd;
    logic [5:0] row;
    logic [5:0] col;
    logic [1:0] val;
  } cmd_item_t;

  typedef struct {
    logic [1:0] cell_val;
    logic [1:0] kind;
  } cell_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // row[5:0], column[11:6], cell_in[13:12]
  logic [1:0]  s_tuser = '0;  // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // cell_out[1:0]
  logic [1:0]  m_tuser;       // finished_kind
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [tsla_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  three_state_life_automaton dut (.*);

  always #4 clk = ~clk;

  cmd_item_t    cmd_queue[$];
  cell_result_t expected_cells[$];
  logic [1:0]   grid_now [0:tsla_pkg::GRID_SIDE*tsla_pkg::GRID_SIDE-1];
  logic [15:0]  gens_cfg = 16'd1;
  int           errors = 0;
  logic         in_fire = 1'b0;

  // ---------------- predictor ----------------
  function automatic bit is_alive(int r, int c);
    if (r < 0 || c < 0 || r >= tsla_pkg::GRID_SIDE || c >= tsla_pkg::GRID_SIDE) return 1'b0;
    return grid_now[r*tsla_pkg::GRID_SIDE + c] == tsla_pkg::CELL_ALIVE;
  endfunction

  function automatic bit evolve_once();
    logic [1:0] nxt [0:tsla_pkg::GRID_SIDE*tsla_pkg::GRID_SIDE-1];
    int cnt;
    int idx;
    bit changed;
    logic [1:0] cur;
    changed = 1'b0;
    for (int r = 0; r < tsla_pkg::GRID_SIDE; r++) begin
      for (int c = 0; c < tsla_pkg::GRID_SIDE; c++) begin
        cnt = 0;
        idx = r*tsla_pkg::GRID_SIDE + c;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0) cnt += int'(is_alive(r + dr, c + dc));
        cur = grid_now[idx];
        nxt[idx] = cur;
        case (cur)
          tsla_pkg::CELL_EMPTY:   if (cnt == 3) nxt[idx] = tsla_pkg::CELL_ALIVE;
          tsla_pkg::CELL_DORMANT: if (cnt == 2) nxt[idx] = tsla_pkg::CELL_ALIVE;
          tsla_pkg::CELL_ALIVE: begin
            if (cnt < 2) nxt[idx] = tsla_pkg::CELL_EMPTY;
            else if (cnt > 3) nxt[idx] = tsla_pkg::CELL_DORMANT;
          end
          default: ;
        endcase
        if (nxt[idx] != cur) changed = 1'b1;
      end
    end
    if (changed) grid_now = nxt;
    return changed;
  endfunction

  // returns 0 when the command gives no result
  function automatic bit run_command(cmd_item_t it, output cell_result_t res);
    int left;
    res.cell_val = tsla_pkg::CELL_EMPTY;
    res.kind     = it.cmd;
    case (it.cmd)
      tsla_pkg::CMD_WRITE:
        if (it.val != tsla_pkg::CELL_BAD) grid_now[it.row*tsla_pkg::GRID_SIDE + it.col] = it.val;
      tsla_pkg::CMD_ADVANCE: begin
        left = int'(gens_cfg);
        while (left > 0) begin
          if (!evolve_once()) break;
          left--;
        end
      end
      tsla_pkg::CMD_READ: res.cell_val = grid_now[it.row*tsla_pkg::GRID_SIDE + it.col];
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // ---------------- driver ----------------
  int  burst_left = 0;
  int  gap_left = 0;
  bit  steady = 1'b0;

  always @(negedge clk) begin
    cmd_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_fire) begin
      // hold until the transfer happens
    end else if (gap_left > 0) begin
      gap_left--;
      s_tvalid <= 1'b0;
    end else if (cmd_queue.size() > 0) begin
      it = cmd_queue.pop_front();
      s_tvalid <= 1'b1;
      s_tdata  <= {2'b00, it.val, it.col, it.row};
      s_tuser  <= it.cmd;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        steady = ($urandom_range(0, 3) == 0);
        gap_left = steady ? 0 : $urandom_range(0, 5);
      end else begin
        burst_left--;
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // ---------------- receiver ----------------
  int  hold_cnt = 0;
  bit  hold_req = 1'b0;
  int  pattern_cnt = 0;

  always @(negedge clk) begin
    pattern_cnt++;
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 400;
      m_tready <= 1'b0;
    end else if ((pattern_cnt / 40) % 2 == 1) begin
      m_tready <= ($urandom_range(0, 2) == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    cmd_item_t    it;
    cell_result_t res;
    cell_result_t want;
    in_fire <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      it.row = s_tdata[5:0];
      it.col = s_tdata[11:6];
      it.val = s_tdata[13:12];
      it.cmd = s_tuser;
      if (run_command(it, res)) expected_cells.push_back(res);
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cells.size() == 0) begin
        $error("unexpected result transfer: cell_out %0d finished_kind %0d",
               m_tdata[1:0], m_tuser);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        if (m_tdata[1:0] !== want.cell_val) begin
          $error("cell_out expected %0d actual %0d", want.cell_val, m_tdata[1:0]);
          errors++;
        end
        if (m_tuser !== want.kind) begin
          $error("finished_kind expected %0d actual %0d", want.kind, m_tuser);
          errors++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_cmd(logic [1:0] cmd, int r, int c, logic [1:0] v);
    cmd_item_t it;
    it.cmd = cmd;
    it.row = r[5:0];
    it.col = c[5:0];
    it.val = v;
    cmd_queue.push_back(it);
  endtask

  task automatic wait_idle();
    while (cmd_queue.size() > 0 || s_tvalid || expected_cells.size() > 0) @(negedge clk);
    // a trailing unused command may still be in work
    repeat (20) @(negedge clk);
  endtask

  task automatic set_generations(logic [15:0] g);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {16'd0, g};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    gens_cfg = g;
  endtask

  task automatic random_round(int n, int win);
    int base_r, base_c, pick;
    base_r = $urandom_range(0, 63 - win);
    base_c = $urandom_range(0, 63 - win);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)
        push_cmd(tsla_pkg::CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                 2'($urandom_range(0, 3)));
      else if (pick < 13)
        push_cmd(tsla_pkg::CMD_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                 2'($urandom_range(0, 3)));
      else if (pick < 18)
        push_cmd($urandom_range(0, 1) ? tsla_pkg::CMD_WRITE : tsla_pkg::CMD_READ,
                 $urandom_range(0, 63), $urandom_range(0, 63), 2'($urandom_range(0, 3)));
      else if (pick < 65)
        push_cmd(tsla_pkg::CMD_WRITE, base_r + $urandom_range(0, win),
                 base_c + $urandom_range(0, win),
                 ($urandom_range(0, 9) == 0) ? tsla_pkg::CELL_BAD : 2'($urandom_range(0, 2)));
      else
        push_cmd(tsla_pkg::CMD_READ, base_r + $urandom_range(0, win),
                 base_c + $urandom_range(0, win), 2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    foreach (grid_now[i]) grid_now[i] = tsla_pkg::CELL_EMPTY;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset
    @(posedge s_tready);

    // largest count on stable grids: empty, then a still block
    set_generations(16'hFFFF);
    push_cmd(tsla_pkg::CMD_ADVANCE, 0, 0, tsla_pkg::CELL_EMPTY);
    push_cmd(tsla_pkg::CMD_WRITE, 10, 10, tsla_pkg::CELL_ALIVE);
    push_cmd(tsla_pkg::CMD_WRITE, 10, 11, tsla_pkg::CELL_ALIVE);
    push_cmd(tsla_pkg::CMD_WRITE, 11, 10, tsla_pkg::CELL_ALIVE);
    push_cmd(tsla_pkg::CMD_WRITE, 11, 11, tsla_pkg::CELL_ALIVE);
    push_cmd(tsla_pkg::CMD_ADVANCE, 63, 63, tsla_pkg::CELL_BAD);
    push_cmd(tsla_pkg::CMD_READ, 11, 11, tsla_pkg::CELL_EMPTY);
    wait_idle();

    set_generations(16'd0);
    push_cmd(tsla_pkg::CMD_WRITE, 0, 0, tsla_pkg::CELL_ALIVE);
    push_cmd(tsla_pkg::CMD_ADVANCE, 0, 0, tsla_pkg::CELL_EMPTY);
    push_cmd(tsla_pkg::CMD_READ, 0, 0, tsla_pkg::CELL_EMPTY);
    wait_idle();

    // corners, bad value, unused command, dormant revival and overcrowding
    set_generations(16'd1);
    push_cmd(tsla_pkg::CMD_WRITE, 63, 63, tsla_pkg::CELL_DORMANT);
    push_cmd(tsla_pkg::CMD_WRITE, 0, 63, tsla_pkg::CELL_BAD);
    push_cmd(tsla_pkg::CMD_WRITE, 63, 0, tsla_pkg::CELL_ALIVE);
    push_cmd(tsla_pkg::CMD_NONE, 63, 63, tsla_pkg::CELL_BAD);
    push_cmd(tsla_pkg::CMD_WRITE, 62, 62, tsla_pkg::CELL_ALIVE);
    push_cmd(tsla_pkg::CMD_WRITE, 62, 63, tsla_pkg::CELL_ALIVE);
    push_cmd(tsla_pkg::CMD_WRITE, 30, 30, tsla_pkg::CELL_ALIVE);
    push_cmd(tsla_pkg::CMD_WRITE, 30, 31, tsla_pkg::CELL_ALIVE);
    push_cmd(tsla_pkg::CMD_WRITE, 30, 32, tsla_pkg::CELL_ALIVE);
    push_cmd(tsla_pkg::CMD_WRITE, 31, 31, tsla_pkg::CELL_ALIVE);
    push_cmd(tsla_pkg::CMD_WRITE, 29, 31, tsla_pkg::CELL_ALIVE);
    push_cmd(tsla_pkg::CMD_ADVANCE, 0, 0, tsla_pkg::CELL_EMPTY);
    push_cmd(tsla_pkg::CMD_READ, 63, 63, tsla_pkg::CELL_EMPTY);
    push_cmd(tsla_pkg::CMD_READ, 0, 63, tsla_pkg::CELL_EMPTY);
    push_cmd(tsla_pkg::CMD_READ, 31, 31, tsla_pkg::CELL_EMPTY);
    push_cmd(tsla_pkg::CMD_READ, 30, 31, tsla_pkg::CELL_EMPTY);
    wait_idle();

    set_generations(16'd2);
    hold_req = 1'b1;
    random_round(30, 10);
    wait_idle();
    set_generations(16'd3);
    random_round(30, 12);
    wait_idle();
    set_generations(16'd1);
    random_round(30, 63);
    wait_idle();
    set_generations(16'd5);
    random_round(30, 8);
    wait_idle();

    if (errors == 0) begin
      $display("PASS three_state_life_automaton");
    end else begin
      $display("FAIL three_state_life_automaton");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL three_state_life_automaton");
    $finish;
  end

endmodule
